// ----- hw/rtl/aabr_pkg.sv -----
// aabr_pkg: shared types and codes for the alpha-aware box resize block
// no dependencies; used by the channel interfaces and the core
package aabr_pkg;

	localparam int unsigned SIZE_W  = 7;
	localparam int unsigned COORD_W = 6;
	localparam int unsigned CHAN_W  = 8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_REQ  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BND,
		ST_BOX,
		ST_WALK,
		ST_DRAIN,
		ST_MEAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [CHAN_W-1:0]  in_red;
		logic [CHAN_W-1:0]  in_green;
		logic [CHAN_W-1:0]  in_blue;
		logic [CHAN_W-1:0]  in_alpha;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              bad_coord;
	} out_item_t;

endpackage

// ----- hw/rtl/aabr_ifs.sv -----
// aabr_ifs: valid/ready channels for command beats and result beats
// depends on aabr_pkg
interface aabr_req_if;
	import aabr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aabr_rsp_if;
	import aabr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/alpha_aware_box_resize_core.sv -----
// alpha_aware_box_resize_core: box-filter RGBA resize with transparent pixels
// kept out of the colour mean; depends on aabr_pkg, aabr_ifs, aabr_store, aabr_div
//
// A load beat (cmd 0) writes one source pixel; loads can follow back to back. A
// request beat (cmd 1) walks the source pixels of its box (one memory read a cycle)
// and uses the shared divider, NUM_W wide (22 for a 64x64 store): four divisions fix
// the box bounds, four more form the rounded means, one quotient bit per cycle.
// An all-transparent box skips the mean divisions. A request outside the target size
// returns at once with bad_coord set. The pixel memory needs no clearing pass;
// pixels must be loaded before a request reads them. A finished result waits in
// an output register while the next beat is taken.
module alpha_aware_box_resize_core #(
	parameter int unsigned MAX_WIDTH  = 64,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_idx,
	input  logic [aabr_pkg::SIZE_W-1:0] cfg_wdata,
	aabr_req_if.sink                req,
	aabr_rsp_if.source              rsp
);
	import aabr_pkg::*;

	localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW     = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W  = CHAN_W + CW;
	localparam int unsigned NUM_W  = (SUM_W + 1 > 13) ? SUM_W + 1 : 13;
	localparam int unsigned DEN_W  = (CW + 1 > 8) ? CW + 1 : 8;

	// configuration
	logic [SIZE_W-1:0] sw_reg_q, sh_reg_q, tw_reg_q, th_reg_q;
	logic [SIZE_W-1:0] sw, sh, tw, th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_reg_q <= SIZE_W'(64);
			sh_reg_q <= SIZE_W'(64);
			tw_reg_q <= SIZE_W'(32);
			th_reg_q <= SIZE_W'(32);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SRC_W: sw_reg_q <= cfg_wdata;
				REG_SRC_H: sh_reg_q <= cfg_wdata;
				REG_DST_W: tw_reg_q <= cfg_wdata;
				REG_DST_H: th_reg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		sw = (sw_reg_q == '0) ? SIZE_W'(1) :
			(32'(sw_reg_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : sw_reg_q;
		sh = (sh_reg_q == '0) ? SIZE_W'(1) :
			(32'(sh_reg_q) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : sh_reg_q;
		tw = (tw_reg_q == '0) ? SIZE_W'(1) : (tw_reg_q > SIZE_W'(64)) ? SIZE_W'(64) : tw_reg_q;
		th = (th_reg_q == '0) ? SIZE_W'(1) : (th_reg_q > SIZE_W'(64)) ? SIZE_W'(64) : th_reg_q;
	end

	// inclusive box bounds from centre, half-ratio quotient and remainder flag
	function automatic logic [2*SIZE_W-1:0] calc_bounds(
		input logic [SIZE_W-1:0] c,
		input logic [SIZE_W-1:0] q,
		input logic              rnz,
		input logic [SIZE_W-1:0] old
	);
		logic signed [SIZE_W+1:0] s;
		logic [SIZE_W:0]          lo, hi, lim;
		s   = (SIZE_W+2)'(signed'({2'b00, c}) + 1 - signed'({2'b00, q})
			- signed'({{(SIZE_W+1){1'b0}}, rnz}));
		lim = {1'b0, old} - 1'b1;
		lo  = (s < 0) ? '0 : s[SIZE_W:0];
		if (lo > lim) begin
			lo = lim;
		end
		hi = {1'b0, c} + {1'b0, q};
		if (hi < lo + 1'b1) begin
			hi = lo + 1'b1;
		end
		if (hi > lim) begin
			hi = lim;
		end
		return {lo[SIZE_W-1:0], hi[SIZE_W-1:0]};
	endfunction

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic       go_q;
	logic       req_fire, is_req, coord_bad;
	logic [COORD_W-1:0] rx_q, ry_q;
	logic       bad_q;

	logic [SIZE_W-1:0] cx_q, qx_q, cy_q, qy_q;
	logic              rnzx_q, rnzy_q;
	logic [SIZE_W-1:0] x0_q, x1_q, y0_q, y1_q, ix_q, iy_q;
	logic [2*SIZE_W-1:0] box_x, box_y;
	logic              rd_valid_s1;

	logic [SUM_W-1:0] sr_q, sg_q, sb_q, sa_q;
	logic [CW-1:0]    ncol_q, ntot_q;
	logic [CHAN_W-1:0] mr_q, mg_q, mb_q, ma_q;

	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        out_free;

	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den, div_rem;

	logic          walk_issue, walk_last;
	logic [31:0]   rdata;
	logic [AW-1:0] raddr, waddr;
	logic          mem_we;

	assign req_fire  = req.valid && req.ready;
	assign is_req    = req.data.cmd == CMD_REQ;
	assign coord_bad = ({1'b0, req.data.coord_x} >= tw) || ({1'b0, req.data.coord_y} >= th);
	assign out_free  = !out_valid_q || rsp.ready;
	assign walk_last = (ix_q == x1_q) && (iy_q == y1_q);
	assign box_x     = calc_bounds(cx_q, qx_q, rnzx_q, sw);
	assign box_y     = calc_bounds(cy_q, qy_q, rnzy_q, sh);

	// loads go straight into the store
	assign mem_we = req_fire && !is_req && (32'(req.data.coord_x) < MAX_WIDTH)
		&& (32'(req.data.coord_y) < MAX_HEIGHT);
	assign waddr  = AW'(32'(req.data.coord_y) * MAX_WIDTH + 32'(req.data.coord_x));
	assign raddr  = AW'(32'(iy_q) * MAX_WIDTH + 32'(ix_q));

	aabr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata ({req.data.in_alpha, req.data.in_blue, req.data.in_green, req.data.in_red}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// divider operand selection
	always_comb begin
		div_num = '0;
		div_den = '0;
		if (state_q == ST_BND) begin
			case (op_q)
				2'd0: begin
					div_num = NUM_W'(13'(rx_q) * 13'(sw));
					div_den = DEN_W'(tw);
				end
				2'd1: begin
					div_num = NUM_W'(sw);
					div_den = DEN_W'({tw, 1'b0});
				end
				2'd2: begin
					div_num = NUM_W'(13'(ry_q) * 13'(sh));
					div_den = DEN_W'(th);
				end
				default: begin
					div_num = NUM_W'(sh);
					div_den = DEN_W'({th, 1'b0});
				end
			endcase
		end else begin
			case (op_q)
				2'd0: div_num = NUM_W'({sr_q, 1'b0}) + NUM_W'(ncol_q);
				2'd1: div_num = NUM_W'({sg_q, 1'b0}) + NUM_W'(ncol_q);
				2'd2: div_num = NUM_W'({sb_q, 1'b0}) + NUM_W'(ncol_q);
				default: div_num = NUM_W'({sa_q, 1'b0}) + NUM_W'(ntot_q);
			endcase
			div_den = (op_q == 2'd3) ? DEN_W'({ntot_q, 1'b0}) : DEN_W'({ncol_q, 1'b0});
		end
	end

	aabr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && is_req) begin
					state_d = coord_bad ? ST_DONE : ST_BND;
				end
			end
			ST_BND: begin
				if (div_done && op_q == 2'd3) begin
					state_d = ST_BOX;
				end
			end
			ST_BOX: state_d = ST_WALK;
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			// the last pixel of the box is still on the read port here
			ST_DRAIN: state_d = (ncol_q == '0 && rdata[31:24] == '0) ? ST_DONE : ST_MEAN;
			ST_MEAN: begin
				if (div_done && op_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready  = 1'b0;
		div_start  = 1'b0;
		walk_issue = 1'b0;
		case (state_q)
			ST_IDLE: req.ready  = 1'b1;
			ST_BND:  div_start  = go_q;
			ST_WALK: walk_issue = 1'b1;
			ST_MEAN: div_start  = go_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			go_q        <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= walk_issue;
			go_q        <= 1'b0;
			if (state_q == ST_IDLE && state_d == ST_BND) begin
				op_q <= '0;
				go_q <= 1'b1;
			end else if (state_q == ST_DRAIN && state_d == ST_MEAN) begin
				op_q <= '0;
				go_q <= 1'b1;
			end else if (div_done && op_q != 2'd3) begin
				op_q <= op_q + 1'b1;
				go_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_fire && is_req) begin
			rx_q  <= req.data.coord_x;
			ry_q  <= req.data.coord_y;
			bad_q <= coord_bad;
			sr_q  <= '0;
			sg_q  <= '0;
			sb_q  <= '0;
			sa_q  <= '0;
			ncol_q <= '0;
			ntot_q <= '0;
			mr_q  <= '0;
			mg_q  <= '0;
			mb_q  <= '0;
			ma_q  <= '0;
		end
		if (state_q == ST_BND && div_done) begin
			case (op_q)
				2'd0: cx_q <= div_quo[SIZE_W-1:0];
				2'd1: begin
					qx_q   <= div_quo[SIZE_W-1:0];
					rnzx_q <= div_rem != '0;
				end
				2'd2: cy_q <= div_quo[SIZE_W-1:0];
				default: begin
					qy_q   <= div_quo[SIZE_W-1:0];
					rnzy_q <= div_rem != '0;
				end
			endcase
		end
		if (state_q == ST_BOX) begin
			{x0_q, x1_q} <= box_x;
			{y0_q, y1_q} <= box_y;
			ix_q <= box_x[2*SIZE_W-1:SIZE_W];
			iy_q <= box_y[2*SIZE_W-1:SIZE_W];
		end
		if (walk_issue) begin
			if (ix_q == x1_q) begin
				ix_q <= x0_q;
				iy_q <= iy_q + 1'b1;
			end else begin
				ix_q <= ix_q + 1'b1;
			end
		end
		// pixel data lands in the cycle after its address
		if (rd_valid_s1) begin
			ntot_q <= ntot_q + 1'b1;
			if (rdata[31:24] != '0) begin
				sr_q   <= sr_q + SUM_W'(rdata[7:0]);
				sg_q   <= sg_q + SUM_W'(rdata[15:8]);
				sb_q   <= sb_q + SUM_W'(rdata[23:16]);
				sa_q   <= sa_q + SUM_W'(rdata[31:24]);
				ncol_q <= ncol_q + 1'b1;
			end
		end
		if (state_q == ST_MEAN && div_done) begin
			case (op_q)
				2'd0: mr_q <= div_quo[CHAN_W-1:0];
				2'd1: mg_q <= div_quo[CHAN_W-1:0];
				2'd2: mb_q <= div_quo[CHAN_W-1:0];
				default: ma_q <= div_quo[CHAN_W-1:0];
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			out_item_q.out_red   <= mr_q;
			out_item_q.out_green <= mg_q;
			out_item_q.out_blue  <= mb_q;
			out_item_q.out_alpha <= ma_q;
			out_item_q.bad_coord <= bad_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_item_q;
endmodule

// ----- hw/rtl/aabr_store.sv -----
// aabr_store: pixel memory, one write port and one registered read port
// no dependencies
module aabr_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/aabr_div.sv -----
// aabr_div: restoring divider, one quotient bit per cycle
// no dependencies; shared by the box bound and mean calculations
module aabr_div #(
	parameter int unsigned NUM_W = 22,
	parameter int unsigned DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, work_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where numerator bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], fits};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = work_q;
	assign rem  = rem_q;
endmodule

// ----- bench/tb_alpha_aware_box_resize_core.sv -----
// tb_alpha_aware_box_resize_core: self-checking bench for the alpha-aware box resize core
// depends on aabr_pkg, aabr_ifs and the core; predicts every result beat and compares it
`timescale 1ns / 1ps

module tb_alpha_aware_box_resize_core;
	import aabr_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic [SIZE_W-1:0] cfg_wdata;

	aabr_req_if req ();
	aabr_rsp_if rsp ();

	alpha_aware_box_resize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.rsp(rsp.source)
	);

	localparam int unsigned GRID = 64;

	// shadow of the pixel memory and the size registers
	logic [31:0]       pix_mem [GRID*GRID];
	logic [SIZE_W-1:0] size_reg [4];
	out_item_t         pending_pixels [$];

	int  errors;
	int  n_loads;
	int  n_requests;
	int  n_bad;
	int  n_checked;
	int  sink_stall;
	bit  quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout at %0t", $realtime);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	function automatic int eff_size(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > GRID)
			return GRID;
		return v;
	endfunction

	// inclusive source span on one axis for destination index d
	function automatic void axis_span(input int d, input int old, input int nw,
			output int lo, output int hi);
		int centre;
		int num;
		centre = d * old / nw;
		num = 2 * nw * (centre + 1) - old;
		lo = (num > 0) ? num / (2 * nw) : 0;
		if (lo > old - 1)
			lo = old - 1;
		hi = centre + old / (2 * nw);
		if (hi < lo + 1)
			hi = lo + 1;
		if (hi > old - 1)
			hi = old - 1;
	endfunction

	function automatic logic [7:0] half_up(input longint sum, input longint n);
		return 8'((2 * sum + n) / (2 * n));
	endfunction

	function automatic out_item_t resize_pixel(input in_item_t it);
		out_item_t r;
		int sw, sh, tw, th, x0, x1, y0, y1;
		longint sr, sg, sb, sa, lit, cnt;
		logic [31:0] p;
		r = '0;
		sr = 0; sg = 0; sb = 0; sa = 0; lit = 0; cnt = 0;
		sw = eff_size(size_reg[REG_SRC_W]);
		sh = eff_size(size_reg[REG_SRC_H]);
		tw = eff_size(size_reg[REG_DST_W]);
		th = eff_size(size_reg[REG_DST_H]);
		if (it.coord_x >= tw || it.coord_y >= th) begin
			r.bad_coord = 1'b1;
			return r;
		end
		axis_span(it.coord_x, sw, tw, x0, x1);
		axis_span(it.coord_y, sh, th, y0, y1);
		for (int j = y0; j <= y1; j++) begin
			for (int i = x0; i <= x1; i++) begin
				p = pix_mem[j * GRID + i];
				if (p[31:24] != 0) begin
					sr += p[7:0];
					sg += p[15:8];
					sb += p[23:16];
					sa += p[31:24];
					lit++;
				end
				cnt++;
			end
		end
		if (lit != 0) begin
			r.out_red   = half_up(sr, lit);
			r.out_green = half_up(sg, lit);
			r.out_blue  = half_up(sb, lit);
			r.out_alpha = half_up(sa, cnt);
		end
		return r;
	endfunction

	function automatic void take_beat(input in_item_t it);
		if (it.cmd == CMD_LOAD) begin
			pix_mem[it.coord_y * GRID + it.coord_x] =
				{it.in_alpha, it.in_blue, it.in_green, it.in_red};
			n_loads++;
		end else begin
			pending_pixels.push_back(resize_pixel(it));
			n_requests++;
		end
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= it;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		take_beat(it);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
			input logic [SIZE_W-1:0] tw, input logic [SIZE_W-1:0] th);
		logic [SIZE_W-1:0] vals [4];
		vals = '{sw, sh, tw, th};
		for (int k = 0; k < 4; k++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_idx   <= reg_idx_t'(k);
			cfg_wdata <= vals[k];
			size_reg[k] = vals[k];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t load_beat(input int x, input int y);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.cmd     = CMD_LOAD;
		it.coord_x = COORD_W'(x);
		it.coord_y = COORD_W'(y);
		// about a quarter of the pixels fully transparent
		if ($urandom_range(0, 3) == 0)
			it.in_alpha = '0;
		return it;
	endfunction

	function automatic in_item_t request_beat(input int x, input int y);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.cmd     = CMD_REQ;
		it.coord_x = COORD_W'(x);
		it.coord_y = COORD_W'(y);
		return it;
	endfunction

	// sink side: random stall bursts until the quiet stretch
	always @(posedge clk) begin
		if (sink_stall > 0) begin
			sink_stall--;
			rsp.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			sink_stall = $urandom_range(0, 9);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				out_item_t want;
				want = pending_pixels.pop_front();
				n_checked++;
				if (want.bad_coord)
					n_bad++;
				if (rsp.data.out_red !== want.out_red)
					report_mismatch($sformatf("red %0d, want %0d",
						rsp.data.out_red, want.out_red));
				if (rsp.data.out_green !== want.out_green)
					report_mismatch($sformatf("green %0d, want %0d",
						rsp.data.out_green, want.out_green));
				if (rsp.data.out_blue !== want.out_blue)
					report_mismatch($sformatf("blue %0d, want %0d",
						rsp.data.out_blue, want.out_blue));
				if (rsp.data.out_alpha !== want.out_alpha)
					report_mismatch($sformatf("alpha %0d, want %0d",
						rsp.data.out_alpha, want.out_alpha));
				if (rsp.data.bad_coord !== want.bad_coord)
					report_mismatch($sformatf("bad_coord %0b, want %0b",
						rsp.data.bad_coord, want.bad_coord));
			end
		end
	end

	// reset sizes leave the memory unloaded, so only out-of-target requests here
	task automatic test_bad_coord_at_reset();
		send_item(request_beat(32, 0));
		send_item(request_beat(63, 63));
		send_item(request_beat(0, 32));
		send_item(request_beat(31, 40));
		wait_drained();
	endtask

	task automatic test_directed_corners();
		in_item_t it;
		set_sizes(7'd4, 7'd4, 7'd2, 7'd2);
		for (int y = 0; y < 4; y++) begin
			for (int x = 0; x < 4; x++) begin
				it = load_beat(x, y);
				// top-left quadrant all transparent, bottom-right saturated white
				if (x < 2 && y < 2)
					it.in_alpha = '0;
				else if (x >= 2 && y >= 2)
					{it.in_red, it.in_green, it.in_blue, it.in_alpha} = '1;
				else if (x == 0)
					{it.in_red, it.in_green, it.in_blue} = '0;
				send_item(it);
			end
		end
		send_item(request_beat(0, 0));
		send_item(request_beat(1, 0));
		send_item(request_beat(0, 1));
		send_item(request_beat(1, 1));
		send_item(request_beat(2, 0));
		wait_drained();
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
			input logic [SIZE_W-1:0] tw, input logic [SIZE_W-1:0] th, input int beats);
		int ew, eh, etw, eth;
		set_sizes(sw, sh, tw, th);
		ew = eff_size(sw); eh = eff_size(sh);
		etw = eff_size(tw); eth = eff_size(th);
		// fill the whole source area first so no request reads an unloaded pixel
		for (int y = 0; y < eh; y++)
			for (int x = 0; x < ew; x++)
				send_item(load_beat(x, y));
		for (int k = 0; k < beats; k++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_item(load_beat($urandom_range(0, GRID-1), $urandom_range(0, GRID-1)));
			else if (pick < 40)
				send_item(request_beat($urandom_range(0, GRID-1), $urandom_range(0, GRID-1)));
			else
				send_item(request_beat($urandom_range(0, etw-1), $urandom_range(0, eth-1)));
		end
		wait_drained();
	endtask

	task automatic test_size_extremes();
		// zero reads as one, values above the limit saturate
		run_phase(7'd127, 7'd1, 7'd0, 7'd64, 12);
		run_phase(7'd0, 7'd127, 7'd64, 7'd0, 12);
		run_phase(7'd64, 7'd2, 7'd64, 7'd1, 12);
		run_phase(7'd1, 7'd1, 7'd1, 7'd1, 6);
	endtask

	task automatic test_random_resizes();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				quiet = 1'b1;
			run_phase(SIZE_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(1, 8)),
				SIZE_W'($urandom_range(1, 12)), SIZE_W'($urandom_range(1, 12)), 10);
		end
	endtask

	initial begin
		errors = 0; n_loads = 0; n_requests = 0; n_bad = 0; n_checked = 0;
		sink_stall = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		size_reg = '{7'd64, 7'd64, 7'd32, 7'd32};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bad_coord_at_reset();
		test_directed_corners();
		test_size_extremes();
		test_random_resizes();

		$display("covered %0d pixel loads and %0d resize requests (%0d out of target)",
			n_loads, n_requests, n_bad);
		$display("%0d result beats compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
